// ===== sv/fuzzy_subsequence_scorer_macros.svh =====
// Assertion macros for the scorer checker.
`ifndef FUZZY_SUBSEQUENCE_SCORER_MACROS_SVH
`define FUZZY_SUBSEQUENCE_SCORER_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define FSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define FSS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== sv/fss_pkg.sv =====
// Shared types, constants and character helpers of the fuzzy subsequence scorer.
`timescale 1ns / 1ps
`default_nettype none
package fss_pkg;

	localparam int PATTERN_MAX   = 32;
	localparam int CANDIDATE_MAX = 256;
	localparam int CHAR_BITS     = 16;

	localparam int PAT_AW  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int LEN_W   = $clog2(PATTERN_MAX + 1);
	localparam int CNT_W   = $clog2(CANDIDATE_MAX + 1);
	localparam int IDX_W   = $clog2(CANDIDATE_MAX);
	localparam int CFG_W   = 6;
	localparam int POS_W   = 8;
	localparam int SCORE_W = 16;
	localparam int RUN_W   = 6;
	localparam int RUN_MAX = (1 << RUN_W) - 1;

	localparam int SC_EXACT   = 10000;
	localparam int SC_PREFIX  = 5000;
	localparam int SC_WORD    = 50;
	localparam int SC_RUN     = 30;
	localparam int GAP_CAP    = 20;
	localparam int SC_ACRONYM = 200;
	localparam int SC_BASE    = 10;
	localparam int SC_CASE    = 5;
	localparam int LEN_DIV    = 4;
	localparam int GAP_W      = $clog2(GAP_CAP + 1);

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_CHAR  = 2'd1;
	localparam logic [1:0] OP_END   = 2'd2;

	localparam logic REG_PATTERN_LENGTH = 1'b0;

	typedef logic [CHAR_BITS-1:0] char_t;
	typedef logic signed [SCORE_W-1:0] score_t;

	localparam char_t CH_UPPER_A  = char_t'('h41);
	localparam char_t CH_UPPER_Z  = char_t'('h5A);
	localparam char_t CH_LOWER_A  = char_t'('h61);
	localparam char_t CH_LOWER_Z  = char_t'('h7A);
	localparam char_t CASE_OFFSET = char_t'('h20);
	localparam char_t CH_SPACE    = char_t'('h20);
	localparam char_t CH_DASH     = char_t'('h2D);
	localparam char_t CH_UNDER    = char_t'('h5F);
	localparam char_t CH_DOT      = char_t'('h2E);
	localparam char_t CH_SLASH    = char_t'('h2F);
	localparam char_t CH_BSLASH   = char_t'('h5C);
	localparam char_t CH_COLON    = char_t'('h3A);
	localparam char_t CH_PAREN    = char_t'('h28);
	localparam char_t CH_BRACKET  = char_t'('h5B);

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] char_code;
		logic [4:0]  pattern_slot;
	} req_t;

	typedef struct packed {
		logic               has_position;
		logic [7:0]         position;
		logic               matched;
		logic signed [15:0] score;
		logic               too_long;
		logic               last;
	} rsp_t;

	typedef struct packed {
		logic              pat_we;
		logic [PAT_AW-1:0] pat_waddr;
		char_t             pat_wdata;
		logic              pat_re;
		logic [PAT_AW-1:0] pat_raddr;
		logic              pos_we;
		logic [PAT_AW-1:0] pos_waddr;
		logic [IDX_W-1:0]  pos_wdata;
		logic              pos_re;
		logic [PAT_AW-1:0] pos_raddr;
	} store_ctrl_t;

	typedef struct packed {
		logic   clr;
		logic   add;
		score_t operand;
	} alu_ctrl_t;

	function automatic logic is_upper(input char_t c);
		return (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
	endfunction

	function automatic logic is_lower(input char_t c);
		return (c >= CH_LOWER_A) && (c <= CH_LOWER_Z);
	endfunction

	function automatic char_t fold(input char_t c);
		return is_upper(c) ? char_t'(c + CASE_OFFSET) : c;
	endfunction

	function automatic logic is_sep(input char_t c);
		return (c == CH_SPACE) || (c == CH_DASH) || (c == CH_UNDER) ||
			(c == CH_DOT) || (c == CH_SLASH) || (c == CH_BSLASH) ||
			(c == CH_COLON) || (c == CH_PAREN) || (c == CH_BRACKET);
	endfunction

endpackage
`default_nettype wire

// ===== sv/fss_store.sv =====
// Pattern character memory and matched position memory, registered reads.
`timescale 1ns / 1ps
`default_nettype none
module fss_store (
	input  logic                             clk,
	input  fss_pkg::store_ctrl_t             ctrl,
	output fss_pkg::char_t                   pat_rdata,
	output logic [fss_pkg::IDX_W-1:0]        pos_rdata
);

	fss_pkg::char_t            pat_mem_q [fss_pkg::PATTERN_MAX];
	logic [fss_pkg::IDX_W-1:0] pos_mem_q [fss_pkg::PATTERN_MAX];
	fss_pkg::char_t            pat_rdata_q;
	logic [fss_pkg::IDX_W-1:0] pos_rdata_q;

	always_ff @(posedge clk) begin
		if (ctrl.pat_we) begin
			pat_mem_q[ctrl.pat_waddr] <= ctrl.pat_wdata;
		end
		if (ctrl.pat_re) begin
			pat_rdata_q <= pat_mem_q[ctrl.pat_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pos_we) begin
			pos_mem_q[ctrl.pos_waddr] <= ctrl.pos_wdata;
		end
		if (ctrl.pos_re) begin
			pos_rdata_q <= pos_mem_q[ctrl.pos_raddr];
		end
	end

	assign pat_rdata = pat_rdata_q;
	assign pos_rdata = pos_rdata_q;

endmodule
`default_nettype wire

// ===== sv/fss_alu.sv =====
// Shared case-folding comparator and score accumulator.
`timescale 1ns / 1ps
`default_nettype none
module fss_alu (
	input  logic                clk,
	input  logic                arst_n,
	input  fss_pkg::alu_ctrl_t  ctrl,
	input  fss_pkg::char_t      cmp_a,
	input  fss_pkg::char_t      cmp_b,
	output logic                fold_eq,
	output logic                raw_eq,
	output fss_pkg::score_t     acc
);

	fss_pkg::score_t acc_q;
	fss_pkg::score_t sum;

	assign fold_eq = (fss_pkg::fold(cmp_a) == fss_pkg::fold(cmp_b));
	assign raw_eq  = (cmp_a == cmp_b);

	always_comb begin
		sum = (ctrl.clr ? fss_pkg::score_t'(0) : acc_q) + ctrl.operand;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.add) begin
			acc_q <= sum;
		end else if (ctrl.clr) begin
			acc_q <= '0;
		end
	end

	assign acc = acc_q;

endmodule
`default_nettype wire

// ===== sv/fuzzy_subsequence_scorer.sv =====
// Top level of the fuzzy subsequence scorer: sequencer, candidate state and ports.
`timescale 1ns / 1ps
`default_nettype none
// The scorer holds a pattern of up to 32 characters, written slot by slot with
// opcode 0 requests, and scores a candidate string streamed in one character per
// opcode 1 request; an opcode 2 request ends the candidate and produces the
// response run: on a prefix or fuzzy match one item per pattern character with
// the matched candidate position, then a verdict item with last set (exact
// 10000, prefix 5000 minus the extra length, otherwise the summed per-character
// bonuses plus the acronym bonus minus length/4). Requests are taken one at a
// time: a candidate character visits the prefix, greedy and acronym states and,
// if it advances the greedy match, the score states; an end marker passes the
// finish states, a read and a write per emitted position and the verdict, longer
// if the response side stalls. This follows from the single pattern memory read
// port, visited once each for the prefix, greedy and acronym pointers, and from
// the one score adder that adds the score terms in turn. A finished verdict
// waits in the output register while the next request is taken. Set
// pattern_length over the APB port (byte address 0) only while no candidate is
// in flight; pattern memory has no reset, so write every slot in use first.
module fuzzy_subsequence_scorer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  fss_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output fss_pkg::rsp_t rsp_data,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_PFX  = 4'd1;
	localparam logic [3:0] ST_GRD  = 4'd2;
	localparam logic [3:0] ST_ACR  = 4'd3;
	localparam logic [3:0] ST_S1   = 4'd4;
	localparam logic [3:0] ST_S2   = 4'd5;
	localparam logic [3:0] ST_S3   = 4'd6;
	localparam logic [3:0] ST_FIN  = 4'd7;
	localparam logic [3:0] ST_FIN2 = 4'd8;
	localparam logic [3:0] ST_EMRD = 4'd9;
	localparam logic [3:0] ST_EMWR = 4'd10;
	localparam logic [3:0] ST_VERD = 4'd11;

	localparam logic [2:0] VK_LONG   = 3'd0;
	localparam logic [2:0] VK_EMPTY  = 3'd1;
	localparam logic [2:0] VK_MISS   = 3'd2;
	localparam logic [2:0] VK_PREFIX = 3'd3;
	localparam logic [2:0] VK_FUZZY  = 3'd4;

	// control and candidate state
	logic [3:0]                  state_q;
	logic [fss_pkg::CFG_W-1:0]   pattern_length_q;
	logic [fss_pkg::CNT_W-1:0]   cnt_q;
	logic [fss_pkg::LEN_W-1:0]   greedy_q;
	logic [fss_pkg::LEN_W-1:0]   acr_q;
	logic                        prefix_q;
	logic [fss_pkg::IDX_W-1:0]   prev_pos_q;
	logic                        prev_valid_q;
	logic [fss_pkg::RUN_W-1:0]   run_q;
	fss_pkg::char_t              prev_char_q;
	logic                        overflow_q;
	logic                        gm_q;
	logic [2:0]                  kind_q;
	logic [fss_pkg::LEN_W-1:0]   emit_q;
	logic                        rsp_valid_q;

	// per-character working registers
	fss_pkg::char_t              ch_q;
	logic                        ws_q;
	logic                        gz_q;
	logic                        exact_q;
	logic                        run_hit_q;
	logic [fss_pkg::GAP_W-1:0]   gap_sat_q;
	fss_pkg::rsp_t               rsp_q;

	// combinational
	logic [fss_pkg::LEN_W-1:0]   len;
	logic                        req_accept;
	logic                        rsp_free;
	logic                        cfg_write;
	logic                        cnt_full;
	fss_pkg::char_t              cand_c;
	logic                        word_start;
	logic [fss_pkg::IDX_W-1:0]   idx;
	logic [fss_pkg::IDX_W-1:0]   gap;
	logic                        run_hit;
	logic [fss_pkg::GAP_W-1:0]   gap_sat;
	logic [fss_pkg::RUN_W-1:0]   run_next;
	logic                        g_hit;
	logic [2:0]                  kind;
	logic                        verdict_ok;
	fss_pkg::store_ctrl_t        st_ctrl;
	fss_pkg::alu_ctrl_t          alu_ctrl;
	fss_pkg::char_t              pat_rdata;
	logic [fss_pkg::IDX_W-1:0]   pos_rdata;
	logic                        fold_eq;
	logic                        raw_eq;
	fss_pkg::score_t             acc;

	fss_store u_store (
		.clk       (clk),
		.ctrl      (st_ctrl),
		.pat_rdata (pat_rdata),
		.pos_rdata (pos_rdata)
	);

	// the comparator always sees the memory read data against the held character
	fss_alu u_alu (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (alu_ctrl),
		.cmp_a   (pat_rdata),
		.cmp_b   (ch_q),
		.fold_eq (fold_eq),
		.raw_eq  (raw_eq),
		.acc     (acc)
	);

	// pattern lengths above the capacity act as a full pattern
	assign len = (32'(pattern_length_q) > fss_pkg::PATTERN_MAX) ?
		fss_pkg::LEN_W'(fss_pkg::PATTERN_MAX) : fss_pkg::LEN_W'(pattern_length_q);

	assign req_stall  = (state_q != ST_IDLE);
	assign req_accept = req_valid && !req_stall;
	assign rsp_free   = !rsp_valid_q || !rsp_stall;
	assign cfg_write  = psel && penable && pwrite && (paddr[2] == fss_pkg::REG_PATTERN_LENGTH);
	assign cnt_full   = (32'(cnt_q) >= fss_pkg::CANDIDATE_MAX);
	assign cand_c     = fss_pkg::char_t'(req_data.char_code);

	// word start: first position, after a separator, or a lower to upper change
	assign word_start = (cnt_q == '0) || fss_pkg::is_sep(prev_char_q) ||
		(fss_pkg::is_lower(prev_char_q) && fss_pkg::is_upper(cand_c));

	assign idx      = fss_pkg::IDX_W'(cnt_q);
	assign gap      = idx - prev_pos_q - fss_pkg::IDX_W'(1);
	assign run_hit  = prev_valid_q && (gap == '0);
	assign gap_sat  = !prev_valid_q ? '0 :
		(32'(gap) > fss_pkg::GAP_CAP) ? fss_pkg::GAP_W'(fss_pkg::GAP_CAP) :
		fss_pkg::GAP_W'(gap);
	assign run_next = !run_hit ? '0 :
		(32'(run_q) == fss_pkg::RUN_MAX) ? run_q : run_q + 1'b1;
	assign g_hit    = (greedy_q < len) && fold_eq;

	always_comb begin
		if (overflow_q) begin
			kind = VK_LONG;
		end else if (len == '0) begin
			kind = VK_EMPTY;
		end else if ((cnt_q < len) || (greedy_q < len)) begin
			kind = VK_MISS;
		end else if (prefix_q) begin
			kind = VK_PREFIX;
		end else begin
			kind = VK_FUZZY;
		end
	end

	assign verdict_ok = (kind_q == VK_PREFIX) || (kind_q == VK_FUZZY);

	// memory ports: one pattern read a cycle, walking prefix, greedy, acronym
	always_comb begin
		st_ctrl = '0;
		case (state_q)
			ST_IDLE: begin
				st_ctrl.pat_waddr = fss_pkg::PAT_AW'(req_data.pattern_slot);
				st_ctrl.pat_wdata = cand_c;
				st_ctrl.pat_raddr = fss_pkg::PAT_AW'(cnt_q);
				st_ctrl.pat_we    = req_accept && (req_data.opcode == fss_pkg::OP_WRITE) &&
					(32'(req_data.pattern_slot) < fss_pkg::PATTERN_MAX);
				st_ctrl.pat_re    = req_accept && (req_data.opcode == fss_pkg::OP_CHAR) &&
					!cnt_full;
			end
			ST_PFX: begin
				st_ctrl.pat_re    = 1'b1;
				st_ctrl.pat_raddr = fss_pkg::PAT_AW'(greedy_q);
			end
			ST_GRD: begin
				st_ctrl.pat_re    = 1'b1;
				st_ctrl.pat_raddr = fss_pkg::PAT_AW'(acr_q);
				st_ctrl.pos_we    = g_hit;
				st_ctrl.pos_waddr = fss_pkg::PAT_AW'(greedy_q);
				st_ctrl.pos_wdata = idx;
			end
			ST_EMRD: begin
				st_ctrl.pos_re    = 1'b1;
				st_ctrl.pos_raddr = fss_pkg::PAT_AW'(emit_q);
			end
			default: begin
			end
		endcase
	end

	// score adder: one term per cycle
	always_comb begin
		alu_ctrl = '0;
		case (state_q)
			ST_S1: begin
				alu_ctrl.add     = 1'b1;
				alu_ctrl.operand = fss_pkg::score_t'(fss_pkg::SC_BASE +
					(ws_q ? fss_pkg::SC_WORD : 0) + (exact_q ? fss_pkg::SC_CASE : 0));
			end
			ST_S2: begin
				// first pattern character pays for its distance from the start
				alu_ctrl.add     = 1'b1;
				alu_ctrl.operand = gz_q ? -(fss_pkg::score_t'(idx) << 1) : '0;
			end
			ST_S3: begin
				alu_ctrl.add     = 1'b1;
				alu_ctrl.operand = run_hit_q ?
					fss_pkg::score_t'(32'(run_q) * fss_pkg::SC_RUN) :
					-fss_pkg::score_t'(gap_sat_q);
			end
			ST_FIN: begin
				if (kind == VK_PREFIX) begin
					alu_ctrl.clr     = 1'b1;
					alu_ctrl.add     = 1'b1;
					alu_ctrl.operand = (cnt_q == len) ?
						fss_pkg::score_t'(fss_pkg::SC_EXACT) :
						fss_pkg::score_t'(fss_pkg::SC_PREFIX);
				end else if (kind == VK_FUZZY) begin
					alu_ctrl.add     = 1'b1;
					alu_ctrl.operand = (acr_q >= len) ?
						fss_pkg::score_t'(fss_pkg::SC_ACRONYM) : '0;
				end
			end
			ST_FIN2: begin
				alu_ctrl.add     = 1'b1;
				alu_ctrl.operand = (kind_q == VK_PREFIX) ?
					fss_pkg::score_t'(len) - fss_pkg::score_t'(cnt_q) :
					-fss_pkg::score_t'(cnt_q / fss_pkg::LEN_DIV);
			end
			ST_VERD: begin
				alu_ctrl.clr = rsp_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			pattern_length_q <= '0;
			cnt_q            <= '0;
			greedy_q         <= '0;
			acr_q            <= '0;
			prefix_q         <= 1'b1;
			prev_pos_q       <= '0;
			prev_valid_q     <= 1'b0;
			run_q            <= '0;
			prev_char_q      <= '0;
			overflow_q       <= 1'b0;
			gm_q             <= 1'b0;
			kind_q           <= VK_LONG;
			emit_q           <= '0;
			rsp_valid_q      <= 1'b0;
		end else begin
			if (cfg_write) begin
				pattern_length_q <= pwdata[fss_pkg::CFG_W-1:0];
			end
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_accept) begin
						case (req_data.opcode)
							fss_pkg::OP_CHAR: begin
								// drop characters past the candidate limit
								if (cnt_full) begin
									overflow_q <= 1'b1;
								end else begin
									state_q <= ST_PFX;
								end
							end
							fss_pkg::OP_END: begin
								state_q <= ST_FIN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_PFX: begin
					if ((cnt_q < len) && !fold_eq) begin
						prefix_q <= 1'b0;
					end
					state_q <= ST_GRD;
				end
				ST_GRD: begin
					gm_q <= g_hit;
					if (g_hit) begin
						greedy_q     <= greedy_q + 1'b1;
						prev_pos_q   <= idx;
						prev_valid_q <= 1'b1;
						run_q        <= run_next;
					end
					state_q <= ST_ACR;
				end
				ST_ACR: begin
					if ((acr_q < len) && ws_q && fold_eq) begin
						acr_q <= acr_q + 1'b1;
					end
					if (gm_q) begin
						state_q <= ST_S1;
					end else begin
						cnt_q       <= cnt_q + 1'b1;
						prev_char_q <= ch_q;
						state_q     <= ST_IDLE;
					end
				end
				ST_S1: begin
					state_q <= ST_S2;
				end
				ST_S2: begin
					state_q <= ST_S3;
				end
				ST_S3: begin
					cnt_q       <= cnt_q + 1'b1;
					prev_char_q <= ch_q;
					state_q     <= ST_IDLE;
				end
				ST_FIN: begin
					kind_q <= kind;
					emit_q <= '0;
					if ((kind == VK_PREFIX) || (kind == VK_FUZZY)) begin
						state_q <= ST_FIN2;
					end else begin
						state_q <= ST_VERD;
					end
				end
				ST_FIN2: begin
					state_q <= ST_EMRD;
				end
				ST_EMRD: begin
					state_q <= ST_EMWR;
				end
				ST_EMWR: begin
					// hold the position until the output register frees up
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						emit_q      <= emit_q + 1'b1;
						if ((32'(emit_q) + 1) == 32'(len)) begin
							state_q <= ST_VERD;
						end else begin
							state_q <= ST_EMRD;
						end
					end
				end
				ST_VERD: begin
					if (rsp_free) begin
						rsp_valid_q  <= 1'b1;
						cnt_q        <= '0;
						greedy_q     <= '0;
						acr_q        <= '0;
						prefix_q     <= 1'b1;
						prev_pos_q   <= '0;
						prev_valid_q <= 1'b0;
						run_q        <= '0;
						prev_char_q  <= '0;
						overflow_q   <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && req_accept) begin
			ch_q <= cand_c;
			ws_q <= word_start;
		end
		if (state_q == ST_GRD) begin
			gz_q      <= (greedy_q == '0);
			exact_q   <= raw_eq;
			run_hit_q <= run_hit;
			gap_sat_q <= gap_sat;
		end
		if ((state_q == ST_EMWR) && rsp_free) begin
			rsp_q              <= '0;
			rsp_q.has_position <= 1'b1;
			rsp_q.position     <= (kind_q == VK_PREFIX) ?
				fss_pkg::POS_W'(emit_q) : fss_pkg::POS_W'(pos_rdata);
		end
		if ((state_q == ST_VERD) && rsp_free) begin
			rsp_q          <= '0;
			rsp_q.matched  <= verdict_ok || (kind_q == VK_EMPTY);
			rsp_q.score    <= verdict_ok ? acc : '0;
			rsp_q.too_long <= (kind_q == VK_LONG);
			rsp_q.last     <= 1'b1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;
	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == fss_pkg::REG_PATTERN_LENGTH) ?
		32'(pattern_length_q) : 32'd0;

endmodule
`default_nettype wire

// ===== sv/fss_checker.sv =====
// Port-level checker for the fuzzy subsequence scorer and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "fuzzy_subsequence_scorer_macros.svh"
module fss_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input fss_pkg::req_t req_data,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input fss_pkg::rsp_t rsp_data
);

	`FSS_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled response changed")
	`FSS_ASSERT_NEXT(a_end_busy, clk, arst_n, req_valid && !req_stall && (req_data.opcode == fss_pkg::OP_END), req_stall, "end marker did not start scoring")
	`FSS_ASSERT_NEXT(a_write_quick, clk, arst_n, req_valid && !req_stall && (req_data.opcode == fss_pkg::OP_WRITE), !req_stall, "pattern write left the block busy")
	`FSS_ASSERT_NOW(a_pos_busy, clk, arst_n, rsp_valid && !rsp_data.last, req_stall, "request taken before the verdict was issued")

endmodule

bind fuzzy_subsequence_scorer fss_checker u_fss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req_data  (req_data),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_data  (rsp_data)
);
`default_nettype wire
